FILE: rtl/core/cnps_pkg.sv
// Shared types, constants and table functions of the cpio newc stream parser.
package cnps_pkg;

  localparam int unsigned ALIGNMENT = 4;
  localparam int unsigned AlignW    = (ALIGNMENT > 1) ? $clog2(ALIGNMENT) : 1;

  localparam logic [6:0] MagicLast  = 7'd5;
  localparam logic [6:0] MagicLen   = 7'd6;
  localparam logic [6:0] HdrLast    = 7'd109;
  localparam logic [3:0] NibLast    = 4'd7;
  localparam logic [31:0] TrailerLen = 32'd11;

  localparam logic [3:0] FieldMode     = 4'd1;
  localparam logic [3:0] FieldFileSize = 4'd6;
  localparam logic [3:0] FieldMajor    = 4'd9;
  localparam logic [3:0] FieldMinor    = 4'd10;
  localparam logic [3:0] FieldNameSize = 4'd11;

  localparam logic [3:0] ModeTypeReg  = 4'o10;
  localparam logic [3:0] ModeTypeLink = 4'o12;

  localparam logic [1:0] QDepth = 2'd2;

  typedef enum logic [2:0] {
    KIND_NAME_BYTE     = 3'd0,
    KIND_ENTRY         = 3'd1,
    KIND_CONTENT       = 3'd2,
    KIND_TRAILER       = 3'd3,
    KIND_BAD_MAGIC     = 3'd4,
    KIND_NAME_UNTERM   = 3'd5,
    KIND_PREMATURE_END = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        content_last;
    logic [31:0] mode_bits;
    logic        regular_or_link;
    logic [31:0] content_length;
    logic [31:0] major_number;
    logic [31:0] minor_number;
    logic [31:0] name_length;
    logic        run_last;
  } result_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = "0";
      3'd1: ch = "7";
      3'd2: ch = "0";
      3'd3: ch = "7";
      3'd4: ch = "0";
      3'd5: ch = "1";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0: ch = "T";
      4'd1: ch = "R";
      4'd2: ch = "A";
      4'd3: ch = "I";
      4'd4: ch = "L";
      4'd5: ch = "E";
      4'd6: ch = "R";
      4'd7: ch = "!";
      4'd8: ch = "!";
      4'd9: ch = "!";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_reg_or_link(input logic [31:0] mode);
    return (mode[15:12] == ModeTypeReg) || (mode[15:12] == ModeTypeLink);
  endfunction

endpackage

FILE: rtl/core/cnps_if.sv
// Valid/ready stream interfaces for archive bytes in and parse results out.
interface cnps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] archive_byte;
  logic       image_end;

  modport source (output valid, output archive_byte, output image_end, input ready);
  modport sink (input valid, input archive_byte, input image_end, output ready);
endinterface

interface cnps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [7:0]  out_byte;
  logic        content_last;
  logic [31:0] mode_bits;
  logic        regular_or_link;
  logic [31:0] content_length;
  logic [31:0] major_number;
  logic [31:0] minor_number;
  logic [31:0] name_length;
  logic        run_last;

  modport source (
    output valid, output result_kind, output out_byte, output content_last,
    output mode_bits, output regular_or_link, output content_length,
    output major_number, output minor_number, output name_length, output run_last,
    input ready
  );
  modport sink (
    input valid, input result_kind, input out_byte, input content_last,
    input mode_bits, input regular_or_link, input content_length,
    input major_number, input minor_number, input name_length, input run_last,
    output ready
  );
endinterface

FILE: rtl/core/cnps_engine.sv
// Parse state machine: consumes one archive byte per step, pushes at most one result.
module cnps_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output logic              push_o,
  output cnps_pkg::result_t res_o,
  output logic              end_o
);
  import cnps_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_NAME,
    ST_PAD1,
    ST_CONTENT,
    ST_PAD2,
    ST_IDLE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [31:0]        count_q, count_d;
  logic [31:0]        acc_q, acc_d;
  logic               stop_q, stop_d;
  logic               magic_q, magic_d;
  logic               trail_q, trail_d;
  logic [31:0]        mode_q, mode_d;
  logic [31:0]        fsize_q, fsize_d;
  logic [31:0]        nsize_q, nsize_d;
  logic [31:0]        major_q, major_d;
  logic [31:0]        minor_q, minor_d;
  logic [AlignW-1:0]  off_q, off_d;
  logic [AlignW:0]    off_sum;
  logic [AlignW-1:0]  off_nxt;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - "A" + 8'd10)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  assign off_sum = {1'b0, off_q} + (AlignW + 1)'(1);
  assign off_nxt = (off_sum >= (AlignW + 1)'(ALIGNMENT)) ? '0 : off_sum[AlignW-1:0];

  always_comb begin
    logic        go_content;
    logic        go_after;
    logic        go_header;
    logic        bad;
    logic        hdr;
    logic        tm;
    logic        last;
    logic [6:0]  c;
    logic [6:0]  rel;
    logic [3:0]  fld;
    logic [3:0]  nib;
    logic [31:0] acc_t;
    logic        stop_t;
    logic [4:0]  hx;
    logic [31:0] cn;

    phase_d = phase_q;
    count_d = count_q;
    acc_d   = acc_q;
    stop_d  = stop_q;
    magic_d = magic_q;
    trail_d = trail_q;
    mode_d  = mode_q;
    fsize_d = fsize_q;
    nsize_d = nsize_q;
    major_d = major_q;
    minor_d = minor_q;
    off_d   = off_q;
    go_content = 1'b0;
    go_after   = 1'b0;
    go_header  = 1'b0;
    bad    = 1'b0;
    hdr    = 1'b0;
    tm     = trail_q;
    last   = 1'b0;
    c      = count_q[6:0];
    rel    = c - MagicLen;
    fld    = rel[6:3];
    nib    = {1'b0, rel[2:0]};
    acc_t  = acc_q;
    stop_t = stop_q;
    hx     = hex_digit(byte_i);
    cn     = count_q + 32'd1;
    push_o = 1'b0;
    end_o  = 1'b0;
    res_o  = '0;
    res_o.kind = KIND_NAME_BYTE;

    if (step_i && phase_q != ST_IDLE) begin
      off_d = off_nxt;
      unique case (phase_q)
        ST_HEADER: begin
          if (c < MagicLen) begin
            if (byte_i != magic_char(c[2:0])) magic_d = 1'b0;
            if (c == MagicLast && !magic_d) begin
              push_o     = 1'b1;
              res_o.kind = KIND_BAD_MAGIC;
              phase_d    = ST_IDLE;
              bad        = 1'b1;
            end
          end else begin
            if (nib == 4'd0) begin
              acc_t  = '0;
              stop_t = 1'b0;
            end
            if (!stop_t) begin
              acc_t = {acc_t[27:0], 4'h0};
              if (hx[4]) acc_t[3:0] = hx[3:0];
              else stop_t = 1'b1;
            end
            acc_d  = acc_t;
            stop_d = stop_t;
            if (nib == NibLast) begin
              unique case (fld)
                FieldMode:     mode_d  = acc_t;
                FieldFileSize: fsize_d = acc_t;
                FieldMajor:    major_d = acc_t;
                FieldMinor:    minor_d = acc_t;
                FieldNameSize: nsize_d = acc_t;
                default: ;
              endcase
            end
          end
          if (!bad) begin
            if (c == HdrLast) begin
              if (nsize_d == 32'd0) begin
                push_o     = 1'b1;
                hdr        = 1'b1;
                res_o.kind = KIND_NAME_UNTERM;
                phase_d    = ST_IDLE;
              end else begin
                phase_d = ST_NAME;
                count_d = '0;
                trail_d = 1'b1;
              end
            end else begin
              count_d = cn;
            end
          end
        end
        ST_NAME: begin
          if (count_q < TrailerLen && byte_i != trailer_char(count_q[3:0])) tm = 1'b0;
          trail_d = tm;
          push_o  = 1'b1;
          if (cn != nsize_q) begin
            res_o.kind     = KIND_NAME_BYTE;
            res_o.out_byte = byte_i;
            count_d        = cn;
          end else begin
            hdr = 1'b1;
            if (byte_i != 8'd0) begin
              res_o.kind = KIND_NAME_UNTERM;
              phase_d    = ST_IDLE;
            end else if (tm && nsize_q >= TrailerLen) begin
              res_o.kind = KIND_TRAILER;
              phase_d    = ST_IDLE;
            end else begin
              res_o.kind = KIND_ENTRY;
              if (off_nxt != '0) phase_d = ST_PAD1;
              else go_content = 1'b1;
            end
          end
        end
        ST_PAD1: begin
          if (off_nxt == '0) go_content = 1'b1;
        end
        ST_CONTENT: begin
          count_d = cn;
          last    = (cn == fsize_q);
          if (is_reg_or_link(mode_q)) begin
            push_o             = 1'b1;
            res_o.kind         = KIND_CONTENT;
            res_o.out_byte     = byte_i;
            res_o.content_last = last;
          end
          if (last) go_after = 1'b1;
        end
        ST_PAD2: begin
          if (off_nxt == '0) go_header = 1'b1;
        end
        default: begin
          phase_d = ST_IDLE;
        end
      endcase

      if (go_content) begin
        if (fsize_q == 32'd0) begin
          go_after = 1'b1;
        end else begin
          phase_d = ST_CONTENT;
          count_d = '0;
        end
      end
      if (go_after) begin
        if (off_nxt != '0) phase_d = ST_PAD2;
        else go_header = 1'b1;
      end
      if (go_header) begin
        phase_d = ST_HEADER;
        count_d = '0;
        magic_d = 1'b1;
      end

      if (end_i && phase_d != ST_IDLE) begin
        end_o   = 1'b1;
        phase_d = ST_IDLE;
      end
    end

    if (hdr) begin
      res_o.mode_bits       = mode_d;
      res_o.regular_or_link = is_reg_or_link(mode_d);
      res_o.content_length  = fsize_d;
      res_o.major_number    = major_d;
      res_o.minor_number    = minor_d;
      res_o.name_length     = nsize_d;
    end
    res_o.run_last = !end_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_HEADER;
      count_q <= '0;
      acc_q   <= '0;
      stop_q  <= 1'b0;
      magic_q <= 1'b1;
      trail_q <= 1'b1;
      mode_q  <= '0;
      fsize_q <= '0;
      nsize_q <= '0;
      major_q <= '0;
      minor_q <= '0;
      off_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      magic_q <= magic_d;
      trail_q <= trail_d;
      mode_q  <= mode_d;
      fsize_q <= fsize_d;
      nsize_q <= nsize_d;
      major_q <= major_d;
      minor_q <= minor_d;
      off_q   <= off_d;
    end
  end

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_IDLE |-> !push_o && !end_o)
    else $error("result produced while idle");
  a_idle_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_IDLE |=> phase_q == ST_IDLE)
    else $error("left idle without reset");
  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_o |=> phase_q == ST_IDLE)
    else $error("premature end did not stop the parser");
  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ST_HEADER |-> count_q <= 32'(HdrLast))
    else $error("header position out of range");

endmodule

FILE: rtl/core/cpio_newc_stream_parser_core.sv
// Top level of the cpio newc stream parser: input register, parse engine, result queue.
//
// Usage:
//   in_i   carries one archive byte per item plus image_end on the final byte.
//   out_o  carries parse results: name bytes, entry headers, content bytes,
//          trailer done, and the error kinds (bad magic, unterminated name,
//          premature end). run_last marks the last result of one input byte.
// Path: an accepted byte is held in the input register, the engine parses it as that
//   register advances, and its result is registered in the queue before out_o shows it.
// Throughput: one byte per cycle while out_o.ready is high; each byte yields
//   at most one result except the byte that carries a premature end, which
//   yields two. The two-entry result queue behind the engine sets this figure,
//   and the premature-end result is held in a flag of its own behind the queue.
// Stall: while out_o.ready is low the queue fills; once it holds two
//   results the input register stops advancing, and in_i.ready drops as
//   soon as that register holds a byte.
//   Bytes that give no result (header, padding, skipped content) still
//   flow while the queue is not full.
// Reset: rst_ni clears all control state; the parser waits for a header.
// After the trailer or an error the parser is idle and swallows all further
//   bytes without result until the next reset.
module cpio_newc_stream_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cnps_in_if.sink     in_i,
  cnps_out_if.source  out_o
);
  import cnps_pkg::*;

  logic       ivld_q;
  logic [7:0] ibyte_q;
  logic       iend_q;
  logic       adv;

  logic       push;
  logic       eng_end;
  result_t    eng_res;

  result_t    qmem_q [QDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pend_q;
  logic       pop;
  result_t    head;
  result_t    end_item;

  assign adv        = ivld_q && (cnt_q != QDepth);
  assign in_i.ready = !ivld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      ivld_q <= 1'b1;
    end else if (adv) begin
      ivld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ibyte_q <= in_i.archive_byte;
      iend_q  <= in_i.image_end;
    end
  end

  cnps_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (ibyte_q),
    .end_i  (iend_q),
    .push_o (push),
    .res_o  (eng_res),
    .end_o  (eng_end)
  );

  always_comb begin
    end_item          = '0;
    end_item.kind     = KIND_PREMATURE_END;
    end_item.run_last = 1'b1;
  end

  assign head        = (cnt_q != 2'd0) ? qmem_q[rd_q] : end_item;
  assign out_o.valid = (cnt_q != 2'd0) || pend_q;
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !(pop && cnt_q != 2'd0)) cnt_d = cnt_q + 2'd1;
    else if (!push && pop && cnt_q != 2'd0) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop && cnt_q != 2'd0) rd_q <= !rd_q;
      if (eng_end) pend_q <= 1'b1;
      else if (pop && cnt_q == 2'd0) pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) qmem_q[wr_q] <= eng_res;
  end

  assign out_o.result_kind     = head.kind;
  assign out_o.out_byte        = head.out_byte;
  assign out_o.content_last    = head.content_last;
  assign out_o.mode_bits       = head.mode_bits;
  assign out_o.regular_or_link = head.regular_or_link;
  assign out_o.content_length  = head.content_length;
  assign out_o.major_number    = head.major_number;
  assign out_o.minor_number    = head.minor_number;
  assign out_o.name_length     = head.name_length;
  assign out_o.run_last        = head.run_last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QDepth)
    else $error("result queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> cnt_q != QDepth)
    else $error("push into full result queue");
  a_end_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !push && !eng_end)
    else $error("result produced after premature end");
  a_end_flag_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && !(pop && cnt_q == 2'd0) |=> pend_q)
    else $error("premature end lost before delivery");

endmodule
